// ===== hw/rtl/joystick_chord_detector_defines.svh =====
// ----------------------------------------------------------------------------
// joystick chord detector assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_CHORD_DETECTOR_DEFINES_SVH
`define JOYSTICK_CHORD_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define JCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define JCD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define JCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/jcd_pkg.sv =====
// ----------------------------------------------------------------------------
// jcd_pkg
// shared types and constants of the joystick chord detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jcd_pkg;

    localparam int TYPE_W      = 8;
    localparam int CTRL_W      = 8;
    localparam int VAL_W       = 16;
    localparam int BTN_W       = 16;
    localparam int AXIS_BITS_W = 4;
    localparam int NUM_AXES    = 2;
    localparam int KIND_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // event type codes, low seven bits; bit 7 is the init flag
    localparam logic [KIND_W-1:0] EV_KIND_BUTTON = 7'h01;
    localparam logic [KIND_W-1:0] EV_KIND_AXIS   = 7'h02;
    localparam logic [TYPE_W-1:0] EV_INIT_FLAG   = 8'h80;

    localparam logic signed [VAL_W-1:0] LOW_LIMIT_RST  = -16'sd16384;
    localparam logic signed [VAL_W-1:0] HIGH_LIMIT_RST = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT_MASK  = 3'd0,
        REG_AXIS0_LOW   = 3'd1,
        REG_AXIS0_HIGH  = 3'd2,
        REG_AXIS1_LOW   = 3'd3,
        REG_AXIS1_HIGH  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_AXIS   = 2'd2
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [BTN_W-1:0]         btn_bit;
        logic                     pressed;
        logic                     axis_sel;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

endpackage

// ===== hw/rtl/jcd_ifs.sv =====
// ----------------------------------------------------------------------------
// jcd channel interfaces
// event, chord and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jcd_event_if import jcd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        event_type;
    logic [CTRL_W-1:0]        control_number;
    logic signed [VAL_W-1:0]  event_value;

    modport source (output valid, event_type, control_number, event_value, input ready);
    modport sink   (input valid, event_type, control_number, event_value, output ready);
endinterface

interface jcd_chord_if import jcd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [AXIS_BITS_W-1:0]  chord_axes;
    logic [BTN_W-1:0]        chord_buttons;

    modport source (output valid, chord_axes, chord_buttons, input ready);
    modport sink   (input valid, chord_axes, chord_buttons, output ready);
endinterface

interface jcd_cfg_if import jcd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/jcd_front.sv =====
// ----------------------------------------------------------------------------
// jcd_front
// accepts events and classifies them into button, axis or no-op commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcd_front
    import jcd_pkg::*;
#(
    parameter int NUM_BUTTONS = 16
) (
    jcd_event_if.sink  ev,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [KIND_W-1:0] kind;
    logic              btn_in_range;
    logic              axis_in_range;

    assign kind          = ev.event_type[KIND_W-1:0];
    assign btn_in_range  = (int'(ev.control_number) < NUM_BUTTONS)
                           && (int'(ev.control_number) < BTN_W);
    assign axis_in_range = int'(ev.control_number) < NUM_AXES;

    assign ev.ready = !queue_full;
    assign push     = ev.valid && !queue_full;

    always_comb
    begin
        push_cmd.op       = OP_NONE;
        push_cmd.btn_bit  = BTN_W'(1) << ev.control_number[$clog2(BTN_W)-1:0];
        push_cmd.pressed  = ev.event_value != '0;
        push_cmd.axis_sel = ev.control_number[0];
        push_cmd.value    = ev.event_value;
        priority if (kind == EV_KIND_BUTTON && btn_in_range)
        begin
            push_cmd.op = OP_BUTTON;
        end
        else if (kind == EV_KIND_AXIS && axis_in_range)
        begin
            push_cmd.op = OP_AXIS;
        end
        else
        begin
            push_cmd.op = OP_NONE;
        end
    end

endmodule

// ===== hw/rtl/jcd_queue.sv =====
// ----------------------------------------------------------------------------
// jcd_queue
// short command queue between the classifier and the state update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "joystick_chord_detector_defines.svh"

module jcd_queue
    import jcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    output logic        full,
    output queue_out_t  head,
    input  logic        pop
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;

    assign full       = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `JCD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= QUEUE_CW'(QUEUE_DEPTH))
    `JCD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `JCD_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, count_reg != '0)

endmodule

// ===== hw/rtl/jcd_back.sv =====
// ----------------------------------------------------------------------------
// jcd_back
// held and seen mask update, chord release detection and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "joystick_chord_detector_defines.svh"

module jcd_back
    import jcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    jcd_cfg_if.sink           cfg,
    input  queue_out_t        head,
    output logic              pop,
    jcd_chord_if.source       chord
);

    logic [BTN_W-1:0]         shift_mask_reg;
    logic signed [VAL_W-1:0]  low_limit_reg  [NUM_AXES];
    logic signed [VAL_W-1:0]  high_limit_reg [NUM_AXES];

    logic [BTN_W-1:0]        held_normal_reg, held_normal_next;
    logic [BTN_W-1:0]        held_shift_reg,  held_shift_next;
    logic [AXIS_BITS_W-1:0]  held_axis_reg,   held_axis_next;
    logic [BTN_W-1:0]        seen_btn_reg,    seen_btn_next;
    logic [AXIS_BITS_W-1:0]  seen_axis_reg,   seen_axis_next;

    logic                    out_valid_reg;
    logic [AXIS_BITS_W-1:0]  out_axes_reg;
    logic [BTN_W-1:0]        out_buttons_reg;

    logic                    emit;
    logic                    is_shift;
    logic [1:0]              dir_bits;
    logic                    cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_mask_reg    <= '0;
            low_limit_reg[0]  <= LOW_LIMIT_RST;
            low_limit_reg[1]  <= LOW_LIMIT_RST;
            high_limit_reg[0] <= HIGH_LIMIT_RST;
            high_limit_reg[1] <= HIGH_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_SHIFT_MASK: shift_mask_reg    <= cfg.data;
                REG_AXIS0_LOW:  low_limit_reg[0]  <= cfg.data;
                REG_AXIS0_HIGH: high_limit_reg[0] <= cfg.data;
                REG_AXIS1_LOW:  low_limit_reg[1]  <= cfg.data;
                REG_AXIS1_HIGH: high_limit_reg[1] <= cfg.data;
                default:        ;
            endcase
        end
    end

    assign pop = head.valid && (!out_valid_reg || chord.ready);

    assign is_shift = (shift_mask_reg & head.cmd.btn_bit) != '0;
    assign dir_bits = {head.cmd.value > high_limit_reg[head.cmd.axis_sel],
                       head.cmd.value < low_limit_reg[head.cmd.axis_sel]};

    always_comb
    begin
        held_normal_next = held_normal_reg;
        held_shift_next  = held_shift_reg;
        held_axis_next   = held_axis_reg;
        unique case (head.cmd.op)
            OP_BUTTON:
            begin
                if (is_shift)
                begin
                    held_shift_next = head.cmd.pressed ? (held_shift_reg | head.cmd.btn_bit)
                                                       : (held_shift_reg & ~head.cmd.btn_bit);
                end
                else
                begin
                    held_normal_next = head.cmd.pressed ? (held_normal_reg | head.cmd.btn_bit)
                                                        : (held_normal_reg & ~head.cmd.btn_bit);
                end
            end
            OP_AXIS:
            begin
                if (head.cmd.axis_sel)
                begin
                    held_axis_next = {dir_bits, held_axis_reg[1:0]};
                end
                else
                begin
                    held_axis_next = {held_axis_reg[3:2], dir_bits};
                end
            end
            default: ;
        endcase
        seen_btn_next  = seen_btn_reg | held_normal_next;
        seen_axis_next = seen_axis_reg | held_axis_next;
        emit = (held_normal_next == '0) && (held_axis_next == '0)
               && ((seen_btn_next != '0) || (seen_axis_next != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_normal_reg <= '0;
            held_shift_reg  <= '0;
            held_axis_reg   <= '0;
            seen_btn_reg    <= '0;
            seen_axis_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_normal_reg <= held_normal_next;
                held_shift_reg  <= held_shift_next;
                held_axis_reg   <= held_axis_next;
                seen_btn_reg    <= emit ? '0 : seen_btn_next;
                seen_axis_reg   <= emit ? '0 : seen_axis_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chord.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_axes_reg    <= seen_axis_next;
            out_buttons_reg <= seen_btn_next | held_shift_next;
        end
    end

    assign chord.valid         = out_valid_reg;
    assign chord.chord_axes    = out_axes_reg;
    assign chord.chord_buttons = out_buttons_reg;

    `JCD_ASSERT_NOW(a_idle_seen_clear, clk, rst_n,
        (held_normal_reg == '0) && (held_axis_reg == '0),
        (seen_btn_reg == '0) && (seen_axis_reg == '0))
    `JCD_ASSERT_NEXT(a_emit_clears_seen, clk, rst_n, pop && emit,
        (seen_btn_reg == '0) && (seen_axis_reg == '0) && out_valid_reg)
    `JCD_ASSERT_NOW(a_chord_not_empty, clk, rst_n, out_valid_reg,
        (out_axes_reg != '0) || (out_buttons_reg != '0))

endmodule

// ===== hw/rtl/joystick_chord_detector.sv =====
// ----------------------------------------------------------------------------
// joystick_chord_detector
// tracks held joystick buttons and axis directions and reports each chord
// ----------------------------------------------------------------------------
// Takes one event item per clock cycle while the queue is not full. Events
// are classified on entry, held in a two-entry queue and applied to the
// held and seen masks one item per cycle unless a chord waits unread; a
// chord is offered in the output register once the event releasing the last
// normal button or axis direction is applied. While a chord waits unread,
// at most two more events are queued; then input stalls until it is read.
// Register writes take effect at once and are expected while no item is in
// flight.
`timescale 1ns / 1ps

module joystick_chord_detector
    import jcd_pkg::*;
#(
    parameter int NUM_BUTTONS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    jcd_event_if.sink    ev,
    jcd_cfg_if.sink      cfg,
    jcd_chord_if.source  chord
);

    logic        queue_full;
    logic        push;
    cmd_t        push_cmd;
    queue_out_t  head;
    logic        pop;

    jcd_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .ev         (ev),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    jcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .head     (head),
        .pop      (pop)
    );

    jcd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .pop   (pop),
        .chord (chord)
    );

endmodule

// ===== test/jcd_chord_checker.sv =====
// ----------------------------------------------------------------------------
// jcd_chord_checker
// watches the event, register and chord channels of the chord detector,
// folds every accepted event item into its own copy of the held and seen
// masks and compares each chord item with the oldest chord it predicted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcd_chord_checker
    import jcd_pkg::*;
#(
    parameter int NUM_BUTTONS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ev_valid,
    input  logic                     ev_ready,
    input  logic [TYPE_W-1:0]        event_type,
    input  logic [CTRL_W-1:0]        control_number,
    input  logic signed [VAL_W-1:0]  event_value,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     chord_valid,
    input  logic                     chord_ready,
    input  logic [AXIS_BITS_W-1:0]   chord_axes,
    input  logic [BTN_W-1:0]         chord_buttons,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [AXIS_BITS_W-1:0] LOW_DIR_BITS = 4'b0101;

    typedef struct packed {
        logic [AXIS_BITS_W-1:0] axes;
        logic [BTN_W-1:0]       buttons;
    } chord_t;

    chord_t awaited_chords[$];

    logic [BTN_W-1:0]        shift_sel;
    logic signed [VAL_W-1:0] low_lim  [NUM_AXES];
    logic signed [VAL_W-1:0] high_lim [NUM_AXES];

    logic [BTN_W-1:0]        normal_held;
    logic [BTN_W-1:0]        shift_held;
    logic [BTN_W-1:0]        normal_seen;
    logic [AXIS_BITS_W-1:0]  axis_held;
    logic [AXIS_BITS_W-1:0]  axis_seen;

    function automatic bit fold_event(input logic [TYPE_W-1:0] etype,
                                      input logic [CTRL_W-1:0] num,
                                      input logic signed [VAL_W-1:0] value,
                                      output chord_t chord_out);
        logic [KIND_W-1:0]      kind;
        logic [BTN_W-1:0]       bit_sel;
        logic [AXIS_BITS_W-1:0] pair;
        kind = etype[KIND_W-1:0];
        chord_out = '0;
        if (kind == EV_KIND_BUTTON && num < NUM_BUTTONS && num < BTN_W)
        begin
            bit_sel = BTN_W'(1) << num;
            if ((shift_sel & bit_sel) != '0)
            begin
                shift_held = (value != 0) ? (shift_held | bit_sel) : (shift_held & ~bit_sel);
            end
            else
            begin
                normal_held = (value != 0) ? (normal_held | bit_sel) : (normal_held & ~bit_sel);
            end
        end
        else if (kind == EV_KIND_AXIS && num < NUM_AXES)
        begin
            pair = AXIS_BITS_W'(2'b11) << (2 * num);
            axis_held = axis_held & ~pair;
            if (value < low_lim[num[0]])
            begin
                axis_held = axis_held | (pair & LOW_DIR_BITS);
            end
            if (value > high_lim[num[0]])
            begin
                axis_held = axis_held | (pair & ~LOW_DIR_BITS);
            end
        end
        normal_seen = normal_seen | normal_held;
        axis_seen = axis_seen | axis_held;
        if (normal_held == '0 && axis_held == '0 && (normal_seen != '0 || axis_seen != '0))
        begin
            chord_out.axes = axis_seen;
            chord_out.buttons = normal_seen | shift_held;
            normal_seen = '0;
            axis_seen = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string field, input logic [BTN_W-1:0] want,
                               input logic [BTN_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < REPORT_LIMIT)
            begin
                $display("%0t: chord %s mismatch: expected %h, got %h", $realtime, field, want,
                         got);
            end
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        chord_t oldest;
        chord_t fresh;
        if (!rst_n)
        begin
            shift_sel = '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                low_lim[a] = LOW_LIMIT_RST;
                high_lim[a] = HIGH_LIMIT_RST;
            end
            normal_held = '0;
            shift_held = '0;
            normal_seen = '0;
            axis_held = '0;
            axis_seen = '0;
            awaited_chords.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (chord_valid && chord_ready)
            begin
                if (awaited_chords.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected chord item: axes %h buttons %h", $realtime,
                                 chord_axes, chord_buttons);
                    end
                    mismatches++;
                end
                else
                begin
                    oldest = awaited_chords.pop_front();
                    check_field("axes", BTN_W'(oldest.axes), BTN_W'(chord_axes));
                    check_field("buttons", oldest.buttons, chord_buttons);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHIFT_MASK: shift_sel = cfg_data;
                    REG_AXIS0_LOW:  low_lim[0] = cfg_data;
                    REG_AXIS0_HIGH: high_lim[0] = cfg_data;
                    REG_AXIS1_LOW:  low_lim[1] = cfg_data;
                    REG_AXIS1_HIGH: high_lim[1] = cfg_data;
                    default: ;
                endcase
            end
            if (ev_valid && ev_ready)
            begin
                if (fold_event(event_type, control_number, event_value, fresh))
                begin
                    awaited_chords.push_back(fresh);
                end
            end
            outstanding = awaited_chords.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives joystick event items and register writes into the chord detector
// ----------------------------------------------------------------------------
// A directed run of button, axis and ignored events comes first, then press
// and release gestures with random content mixed with random noise, under
// several register settings including the extremes. Both channels idle at
// random; one stretch holds the chord side off until the block stalls.
`timescale 1ns / 1ps

module tb;
    import jcd_pkg::*;

    localparam int NUM_BUTTONS   = 16;
    localparam int IDLE_PCT      = 15;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 145;
    localparam int VAL_MIN       = -32768;
    localparam int VAL_MAX       = 32767;

    localparam logic [TYPE_W-1:0] BUTTON_EV = {1'b0, EV_KIND_BUTTON};
    localparam logic [TYPE_W-1:0] AXIS_EV   = {1'b0, EV_KIND_AXIS};

    typedef enum int {
        AXIS_NEUTRAL,
        AXIS_BELOW,
        AXIS_ABOVE,
        AXIS_ANY
    } axis_aim_t;

    logic clk;
    logic rst_n;
    int   chk_fail;
    int   chk_outstanding;
    int   cycle_count;
    int   useful;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    int   lim_lo [NUM_AXES];
    int   lim_hi [NUM_AXES];
    logic [BTN_W-1:0]    held_mask;
    logic [NUM_AXES-1:0] axis_off;

    jcd_event_if ev_if ();
    jcd_cfg_if   cfg_if ();
    jcd_chord_if chord_if ();

    joystick_chord_detector #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .ev(ev_if),
        .cfg(cfg_if),
        .chord(chord_if)
    );

    jcd_chord_checker #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .ev_valid(ev_if.valid),
        .ev_ready(ev_if.ready),
        .event_type(ev_if.event_type),
        .control_number(ev_if.control_number),
        .event_value(ev_if.event_value),
        .cfg_valid(cfg_if.valid),
        .cfg_ready(cfg_if.ready),
        .cfg_index(cfg_if.index),
        .cfg_data(cfg_if.data),
        .chord_valid(chord_if.valid),
        .chord_ready(chord_if.ready),
        .chord_axes(chord_if.chord_axes),
        .chord_buttons(chord_if.chord_buttons),
        .mismatches(chk_fail),
        .outstanding(chk_outstanding)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // chord side: random stalls, or a long hold-off on request
    initial
    begin
        chord_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                chord_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            chord_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic logic [TYPE_W-1:0] button_type();
        return {1'($urandom_range(0, 1)), EV_KIND_BUTTON};
    endfunction

    function automatic logic [TYPE_W-1:0] axis_type();
        return {1'($urandom_range(0, 1)), EV_KIND_AXIS};
    endfunction

    function automatic logic signed [VAL_W-1:0] nonzero_value();
        logic signed [VAL_W-1:0] v;
        v = VAL_W'($urandom);
        if (v == 0)
        begin
            v = 1;
        end
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] axis_value(input int axis, input axis_aim_t aim);
        int lo;
        int hi;
        lo = lim_lo[axis];
        hi = lim_hi[axis];
        case (aim)
            AXIS_NEUTRAL: return VAL_W'(lo + int'($urandom_range(0, hi - lo)));
            AXIS_BELOW:
                if (lo > VAL_MIN)
                begin
                    return VAL_W'(VAL_MIN + int'($urandom_range(0, lo - VAL_MIN - 1)));
                end
            AXIS_ABOVE:
                if (hi < VAL_MAX)
                begin
                    return VAL_W'(hi + 1 + int'($urandom_range(0, VAL_MAX - hi - 1)));
                end
            default: ;
        endcase
        return VAL_W'($urandom);
    endfunction

    task automatic send_event(input logic [TYPE_W-1:0] etype, input logic [CTRL_W-1:0] num,
                              input logic signed [VAL_W-1:0] value);
        logic [KIND_W-1:0] kind;
        kind = etype[KIND_W-1:0];
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
        end
        ev_if.event_type = etype;
        ev_if.control_number = num;
        ev_if.event_value = value;
        ev_if.valid = 1'b1;
        @(posedge clk);
        while (!ev_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        ev_if.valid = 1'b0;
        // keep track of what is still held so it can be let go later
        if (kind == EV_KIND_BUTTON && num < NUM_BUTTONS && num < BTN_W)
        begin
            held_mask[num[3:0]] = (value != 0);
            useful++;
        end
        else if (kind == EV_KIND_AXIS && num < NUM_AXES)
        begin
            axis_off[num[0]] = (value < lim_lo[num[0]]) || (value > lim_hi[num[0]]);
            useful++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.index = idx;
        cfg_if.data = data;
        cfg_if.valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic program_limits(input logic [BTN_W-1:0] shift, input int l0, input int h0,
                                  input int l1, input int h1);
        write_reg(REG_SHIFT_MASK, shift);
        write_reg(REG_AXIS0_LOW, CFG_DATA_W'(l0));
        write_reg(REG_AXIS0_HIGH, CFG_DATA_W'(h0));
        write_reg(REG_AXIS1_LOW, CFG_DATA_W'(l1));
        write_reg(REG_AXIS1_HIGH, CFG_DATA_W'(h1));
        lim_lo[0] = l0;
        lim_hi[0] = h0;
        lim_lo[1] = l1;
        lim_hi[1] = h1;
    endtask

    task automatic random_config();
        int a;
        int b;
        int c;
        int d;
        a = int'($signed(VAL_W'($urandom)));
        b = int'($signed(VAL_W'($urandom)));
        c = int'($signed(VAL_W'($urandom)));
        d = int'($signed(VAL_W'($urandom)));
        program_limits(BTN_W'($urandom), (a < b) ? a : b, (a < b) ? b : a,
                       (c < d) ? c : d, (c < d) ? d : c);
        // indexes past the last register must change nothing
        for (int i = REG_AXIS1_HIGH + 1; i < (1 << CFG_IDX_W); i++)
        begin
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        end
    endtask

    task automatic await_chords();
        while (chk_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic release_all();
        for (int b = 0; b < BTN_W; b++)
        begin
            if (held_mask[b])
            begin
                send_event(button_type(), CTRL_W'(b), '0);
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (axis_off[a])
            begin
                send_event(axis_type(), CTRL_W'(a), axis_value(a, AXIS_NEUTRAL));
            end
        end
    endtask

    task automatic play_chord();
        logic [BTN_W-1:0]    picked;
        logic [NUM_AXES-1:0] moved;
        int b;
        int a;
        picked = '0;
        moved = '0;
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                a = $urandom_range(0, NUM_AXES - 1);
                send_event(axis_type(), CTRL_W'(a),
                           axis_value(a, axis_aim_t'($urandom_range(AXIS_BELOW, AXIS_ANY))));
                moved[a] = 1'b1;
            end
            else
            begin
                b = $urandom_range(0, BTN_W - 1);
                send_event(button_type(), CTRL_W'(b), nonzero_value());
                picked[b] = 1'b1;
            end
        end
        while (picked != '0 || moved != '0)
        begin
            if (moved != '0 && (picked == '0 || $urandom_range(0, 2) == 0))
            begin
                a = $urandom_range(0, NUM_AXES - 1);
                if (!moved[a])
                begin
                    a = NUM_AXES - 1 - a;
                end
                send_event(axis_type(), CTRL_W'(a), axis_value(a, AXIS_NEUTRAL));
                moved[a] = 1'b0;
            end
            else
            begin
                do
                begin
                    b = $urandom_range(0, BTN_W - 1);
                end
                while (!picked[b]);
                send_event(button_type(), CTRL_W'(b), '0);
                picked[b] = 1'b0;
            end
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 2))
                0: send_event(TYPE_W'($urandom), CTRL_W'($urandom), VAL_W'($urandom));
                1: send_event(button_type(), CTRL_W'($urandom_range(0, BTN_W - 1)),
                              VAL_W'($urandom));
                default: send_event(axis_type(), CTRL_W'($urandom_range(0, NUM_AXES - 1)),
                                    VAL_W'($urandom));
            endcase
        end
        if ($urandom_range(0, 1) == 0)
        begin
            release_all();
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = useful;
        while (useful - start < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                play_chord();
            end
            else
            begin
                noise_burst();
            end
        end
        release_all();
        await_chords();
    endtask

    initial
    begin
        rst_n = 1'b0;
        ev_if.valid = 1'b0;
        ev_if.event_type = '0;
        ev_if.control_number = '0;
        ev_if.event_value = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        useful = 0;
        held_mask = '0;
        axis_off = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lim_lo[a] = int'(LOW_LIMIT_RST);
            lim_hi[a] = int'(HIGH_LIMIT_RST);
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: button extremes, init flag, limits at and past the edge
        send_event(BUTTON_EV, 8'd0, 16'sd1);
        send_event(BUTTON_EV, 8'd0, 16'sd0);
        send_event(BUTTON_EV | EV_INIT_FLAG, 8'd15, -16'sd32768);
        send_event(BUTTON_EV, 8'd3, 16'sd32767);
        send_event(BUTTON_EV | EV_INIT_FLAG, 8'd15, 16'sd0);
        send_event(BUTTON_EV, 8'd3, 16'sd0);
        send_event(BUTTON_EV, 8'd16, 16'sd1);
        send_event(BUTTON_EV, 8'd255, -16'sd32768);
        send_event(AXIS_EV, 8'd0, -16'sd32768);
        send_event(AXIS_EV, 8'd0, LOW_LIMIT_RST);
        send_event(AXIS_EV | EV_INIT_FLAG, 8'd1, 16'sd32767);
        send_event(AXIS_EV, 8'd1, HIGH_LIMIT_RST);
        send_event(AXIS_EV, 8'd0, HIGH_LIMIT_RST + 16'sd1);
        send_event(AXIS_EV, 8'd1, LOW_LIMIT_RST - 16'sd1);
        send_event(AXIS_EV, 8'd0, 16'sd0);
        send_event(AXIS_EV, 8'd1, 16'sd0);
        send_event(AXIS_EV, 8'd2, -16'sd32768);
        send_event(AXIS_EV, 8'd255, 16'sd32767);
        send_event('0, 8'd0, 16'sd1);
        send_event(TYPE_W'(EV_KIND_AXIS + 1), 8'd1, -16'sd1);
        send_event('1, 8'd255, -16'sd1);
        send_event({1'b0, {KIND_W{1'b1}}}, 8'd7, 16'sd1);
        send_event(BUTTON_EV | EV_INIT_FLAG, 8'd7, 16'sd0);
        await_chords();

        run_phase(PHASE_ITEMS);

        random_config();
        // chord side held off while events keep coming
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (12) play_chord();
        calm = 1'b0;
        run_phase(PHASE_ITEMS);

        program_limits('1, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        calm = 1'b0;

        program_limits('0, VAL_MIN, VAL_MIN, 0, 0);
        run_phase(PHASE_ITEMS);

        random_config();
        run_phase(PHASE_ITEMS);

        if (chk_fail == 0 && chk_outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jcd_pkg.sv
hw/rtl/jcd_ifs.sv
hw/rtl/jcd_front.sv
hw/rtl/jcd_queue.sv
hw/rtl/jcd_back.sv
hw/rtl/joystick_chord_detector.sv
test/jcd_chord_checker.sv
test/tb.sv
